>>> sv/calendar_clock_with_wheel_edit_assert.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_WHEEL_EDIT_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_WHEEL_EDIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define CCWE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCWE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ccwe_pkg.sv
// Types, constants and calendar helpers for the calendar clock.
`timescale 1ns / 1ps

package ccwe_pkg;

    localparam int CMD_W   = 3;
    localparam int WHEEL_W = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int FIELD_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WHEEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 3'd4;

    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd11;
    localparam logic [HOUR_W-1:0]  LAST_HOUR   = 5'd23;
    localparam logic [MIN_W-1:0]   LAST_MIN    = 6'd59;
    localparam logic [SEC_W-1:0]   LAST_SEC    = 6'd59;
    localparam logic [FIELD_W-1:0] LAST_FIELD  = 3'd4;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd3;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd16;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } act_t;

    typedef enum logic [2:0] {
        UNIT_MONTH = 3'd0,
        UNIT_DAY   = 3'd1,
        UNIT_HOUR  = 3'd2,
        UNIT_MIN   = 3'd3,
        UNIT_SEC   = 3'd4
    } unit_t;

    typedef struct packed {
        act_t               act;
        unit_t              unit;
        logic               editing;
        logic [FIELD_W-1:0] field;
    } op_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1:                     len = 5'd29;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [MONTH_W-1:0] next_month(input logic [MONTH_W-1:0] m);
        return (m >= LAST_MONTH) ? 4'd0 : m + 4'd1;
    endfunction

    function automatic logic [MONTH_W-1:0] prev_month(input logic [MONTH_W-1:0] m);
        return (m == 4'd0) ? LAST_MONTH : m - 4'd1;
    endfunction

    function automatic unit_t field_unit(input logic [FIELD_W-1:0] f);
        unit_t u;
        unique case (f)
            3'd0:    u = UNIT_MONTH;
            3'd1:    u = UNIT_DAY;
            3'd2:    u = UNIT_HOUR;
            3'd3:    u = UNIT_MIN;
            default: u = UNIT_SEC;
        endcase
        return u;
    endfunction

endpackage

>>> sv/calendar_clock_with_wheel_edit.sv
// Top level of the calendar clock with wheel editing.
// Path: the queue registers each input item, then the back end registers the result and raises out_valid.
// Throughput: one item per cycle while the queue has room and out_ready holds; each end steps at most once per cycle.
// The queue between them absorbs output stalls up to QUEUE_DEPTH items.
// Reset: day 16 of month 3, 00:00:00, run mode, field 0, last wheel 0, queue empty.
`timescale 1ns / 1ps

module calendar_clock_with_wheel_edit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ccwe_pkg::CMD_W-1:0]   cmd,
    input  logic [ccwe_pkg::WHEEL_W-1:0] wheel_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ccwe_pkg::MONTH_W-1:0] month_index,
    output logic [ccwe_pkg::DAY_W-1:0]   day_of_month,
    output logic [ccwe_pkg::HOUR_W-1:0]  hour_of_day,
    output logic [ccwe_pkg::MIN_W-1:0]   minute_of_hour,
    output logic [ccwe_pkg::SEC_W-1:0]   second_of_minute,
    output logic                         editing,
    output logic [ccwe_pkg::FIELD_W-1:0] selected_field
);
    import ccwe_pkg::*;

    logic q_ready, q_valid, push, pop;
    op_t  push_op, pop_op;

    ccwe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .wheel_sample (wheel_sample),
        .q_ready      (q_ready),
        .push         (push),
        .push_op      (push_op)
    );

    ccwe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .pop     (pop),
        .q_valid (q_valid),
        .pop_op  (pop_op)
    );

    ccwe_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .pop_op           (pop_op),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .editing          (editing),
        .selected_field   (selected_field)
    );

endmodule

>>> sv/ccwe_front.sv
// Front end: command decode, edit mode, field select and wheel compare.
`timescale 1ns / 1ps

module ccwe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ccwe_pkg::CMD_W-1:0]   cmd,
    input  logic [ccwe_pkg::WHEEL_W-1:0] wheel_sample,
    input  logic                         q_ready,
    output logic                         push,
    output ccwe_pkg::op_t                push_op
);
    import ccwe_pkg::*;

    localparam logic [WHEEL_W-1:0] WHEEL_TOP   = 12'd4082;
    localparam logic [WHEEL_W:0]   WHEEL_DELTA = 13'd80;

    logic               edit_reg, edit_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [WHEEL_W-1:0] last_wheel_reg, last_wheel_next;
    logic               wheel_up, wheel_down;
    act_t               op_act;
    unit_t              op_unit;

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    always_comb
    begin
        wheel_up   = (wheel_sample > WHEEL_TOP) ||
                     (({1'b0, last_wheel_reg} + WHEEL_DELTA) < {1'b0, wheel_sample});
        wheel_down = (({1'b0, wheel_sample} + WHEEL_DELTA) < {1'b0, last_wheel_reg});
        edit_next       = edit_reg;
        field_next      = field_reg;
        last_wheel_next = last_wheel_reg;
        op_act          = ACT_NONE;
        op_unit         = UNIT_SEC;
        unique case (cmd)
            CMD_TICK:
            begin
                if (!edit_reg)
                begin
                    op_act = ACT_UP;
                end
            end
            CMD_ENTER:
            begin
                if (!edit_reg)
                begin
                    edit_next       = 1'b1;
                    field_next      = '0;
                    last_wheel_next = wheel_sample;
                end
            end
            CMD_NEXT:
            begin
                if (edit_reg)
                begin
                    field_next = (field_reg >= LAST_FIELD) ? 3'd0 : field_reg + 3'd1;
                end
            end
            CMD_WHEEL:
            begin
                if (edit_reg)
                begin
                    op_unit = field_unit(field_reg);
                    if (wheel_up)
                    begin
                        op_act          = ACT_UP;
                        last_wheel_next = wheel_sample;
                    end
                    else if (wheel_down)
                    begin
                        op_act          = ACT_DOWN;
                        last_wheel_next = wheel_sample;
                    end
                end
            end
            CMD_EXIT:
            begin
                edit_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        push_op.act     = op_act;
        push_op.unit    = op_unit;
        push_op.editing = edit_next;
        push_op.field   = field_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_reg       <= 1'b0;
            field_reg      <= '0;
            last_wheel_reg <= '0;
        end
        else if (push)
        begin
            edit_reg       <= edit_next;
            field_reg      <= field_next;
            last_wheel_reg <= last_wheel_next;
        end
    end

endmodule

>>> sv/ccwe_queue.sv
// Small transfer queue between front end and back end.
`timescale 1ns / 1ps

module ccwe_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ccwe_pkg::op_t push_op,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output ccwe_pkg::op_t pop_op
);
    import ccwe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_op  = mem_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/ccwe_back.sv
// Back end: decoded time registers, carry and borrow stepping, result register.
`timescale 1ns / 1ps
`include "calendar_clock_with_wheel_edit_assert.svh"

module ccwe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  ccwe_pkg::op_t                pop_op,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ccwe_pkg::MONTH_W-1:0] month_index,
    output logic [ccwe_pkg::DAY_W-1:0]   day_of_month,
    output logic [ccwe_pkg::HOUR_W-1:0]  hour_of_day,
    output logic [ccwe_pkg::MIN_W-1:0]   minute_of_hour,
    output logic [ccwe_pkg::SEC_W-1:0]   second_of_minute,
    output logic                         editing,
    output logic [ccwe_pkg::FIELD_W-1:0] selected_field
);
    import ccwe_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic [MONTH_W-1:0] month_reg, month_next, month_alt;
    logic [DAY_W-1:0]   day_reg, day_next, alt_len;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic               editing_reg;
    logic [FIELD_W-1:0] field_reg;
    logic               carry;

    logic                            time_ok;
    logic                            tick_up, hold_step, month_step;
    logic [SEC_W-1:0]                sec_inc;
    logic [HOUR_W+MIN_W+SEC_W-1:0]   tod_vec;
    logic [MONTH_W+DAY_W-1:0]        date_vec;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        month_alt  = '0;
        alt_len    = '0;
        carry      = 1'b0;
        case (pop_op.act)
            ACT_UP:
            begin
                carry = (pop_op.unit == UNIT_SEC);
                if (carry)
                begin
                    if (sec_reg == LAST_SEC)
                    begin
                        sec_next = '0;
                    end
                    else
                    begin
                        sec_next = sec_reg + 6'd1;
                        carry    = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_MIN);
                if (carry)
                begin
                    if (min_reg == LAST_MIN)
                    begin
                        min_next = '0;
                    end
                    else
                    begin
                        min_next = min_reg + 6'd1;
                        carry    = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_HOUR);
                if (carry)
                begin
                    if (hour_reg == LAST_HOUR)
                    begin
                        hour_next = '0;
                    end
                    else
                    begin
                        hour_next = hour_reg + 5'd1;
                        carry     = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_DAY);
                if (carry)
                begin
                    if (day_reg >= month_len(month_reg) - 5'd1)
                    begin
                        day_next   = '0;
                        month_next = next_month(month_reg);
                    end
                    else
                    begin
                        day_next = day_reg + 5'd1;
                    end
                end
                if (pop_op.unit == UNIT_MONTH)
                begin
                    month_alt = next_month(month_reg);
                    alt_len   = month_len(month_alt);
                    if (day_reg >= alt_len)
                    begin
                        month_next = next_month(month_alt);
                        day_next   = day_reg - alt_len;
                    end
                    else
                    begin
                        month_next = month_alt;
                    end
                end
            end
            ACT_DOWN:
            begin
                carry = (pop_op.unit == UNIT_SEC);
                if (carry)
                begin
                    if (sec_reg == '0)
                    begin
                        sec_next = LAST_SEC;
                    end
                    else
                    begin
                        sec_next = sec_reg - 6'd1;
                        carry    = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_MIN);
                if (carry)
                begin
                    if (min_reg == '0)
                    begin
                        min_next = LAST_MIN;
                    end
                    else
                    begin
                        min_next = min_reg - 6'd1;
                        carry    = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_HOUR);
                if (carry)
                begin
                    if (hour_reg == '0)
                    begin
                        hour_next = LAST_HOUR;
                    end
                    else
                    begin
                        hour_next = hour_reg - 5'd1;
                        carry     = 1'b0;
                    end
                end
                carry = carry || (pop_op.unit == UNIT_DAY);
                if (carry)
                begin
                    if (day_reg == '0)
                    begin
                        month_next = prev_month(month_reg);
                        day_next   = month_len(month_next) - 5'd1;
                    end
                    else
                    begin
                        day_next = day_reg - 5'd1;
                    end
                end
                if (pop_op.unit == UNIT_MONTH)
                begin
                    month_alt = prev_month(month_reg);
                    alt_len   = month_len(month_alt);
                    if (day_reg >= alt_len)
                    begin
                        day_next = day_reg - alt_len;
                    end
                    else
                    begin
                        month_next = month_alt;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            month_reg     <= RESET_MONTH;
            day_reg       <= RESET_DAY;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            editing_reg   <= 1'b0;
            field_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                min_reg     <= min_next;
                sec_reg     <= sec_next;
                editing_reg <= pop_op.editing;
                field_reg   <= pop_op.field;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign month_index      = month_reg;
    assign day_of_month     = day_reg;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = min_reg;
    assign second_of_minute = sec_reg;
    assign editing          = editing_reg;
    assign selected_field   = field_reg;

    assign time_ok    = (sec_reg <= LAST_SEC) && (min_reg <= LAST_MIN) &&
                        (hour_reg <= LAST_HOUR) && (month_reg <= LAST_MONTH) &&
                        (day_reg < month_len(month_reg));
    assign tick_up    = pop && (pop_op.act == ACT_UP) && (pop_op.unit == UNIT_SEC);
    assign hold_step  = pop && (pop_op.act == ACT_NONE);
    assign month_step = pop && (pop_op.act != ACT_NONE) && (pop_op.unit == UNIT_MONTH);
    assign sec_inc    = (sec_reg == LAST_SEC) ? '0 : sec_reg + 6'd1;
    assign tod_vec    = {hour_reg, min_reg, sec_reg};
    assign date_vec   = {month_reg, day_reg};

    `CCWE_ASSERT_ALWAYS(a_time_in_range, time_ok, "decoded time out of range")
    `CCWE_ASSERT_NEXT(a_tick_second, tick_up, sec_reg == $past(sec_inc), "second step wrong")
    `CCWE_ASSERT_NEXT(a_no_step_holds, hold_step, $stable({date_vec, tod_vec}), "time moved")
    `CCWE_ASSERT_NEXT(a_month_keeps_clock, month_step, $stable(tod_vec), "month step moved clock")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the calendar clock with wheel editing.
`timescale 1ns / 1ps

module tb_top;
    import ccwe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int SEC_DAY     = 86400;
    localparam int SEC_HOUR    = 3600;
    localparam int YEAR_SECS   = 366 * SEC_DAY;
    localparam int WHEEL_TOP   = 4082;
    localparam int WHEEL_DELTA = 80;
    localparam int RAND_ITEMS  = 1550;
    localparam int WATCHDOG    = 4000;
    localparam int DIR_ROWS    = 26;

    typedef struct packed {
        logic [MONTH_W-1:0] mon;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hr;
        logic [MIN_W-1:0]   mins;
        logic [SEC_W-1:0]   secs;
        logic               edit;
        logic [FIELD_W-1:0] field;
    } time_rec_t;

    typedef struct packed {
        logic [CMD_W-1:0]   c;
        logic [WHEEL_W-1:0] w;
        logic               typed;
        time_rec_t          want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd = '0;
    logic [WHEEL_W-1:0]   wheel_sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [MONTH_W-1:0]   month_index;
    logic [DAY_W-1:0]     day_of_month;
    logic [HOUR_W-1:0]    hour_of_day;
    logic [MIN_W-1:0]     minute_of_hour;
    logic [SEC_W-1:0]     second_of_minute;
    logic                 editing;
    logic [FIELD_W-1:0]   selected_field;

    int                   clock_secs;
    logic                 edit_on;
    logic [FIELD_W-1:0]   cur_field;
    logic [WHEEL_W-1:0]   prev_wheel;

    time_rec_t            expected_times [$];
    time_rec_t            got_time;
    time_rec_t            want_time;
    int                   bad_count = 0;
    int                   idle_cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    int                   rand_sent = 0;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{CMD_TICK,  12'd0,    1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_RSVD5, 12'hfff,  1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_RSVD7, 12'd0,    1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_NEXT,  12'hfff,  1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_WHEEL, 12'hfff,  1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_EXIT,  12'd0,    1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b0, 3'd0}},
        '{CMD_ENTER, 12'd0,    1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b1, 3'd0}},
        '{CMD_TICK,  12'd0,    1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b1, 3'd0}},
        '{CMD_ENTER, 12'd2000, 1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b1, 3'd0}},
        '{CMD_WHEEL, 12'd80,   1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b1, 3'd0}},
        '{CMD_RSVD6, 12'hfff,  1'b1, '{4'd3, 5'd16, 5'd0, 6'd0, 6'd1, 1'b1, 3'd0}},
        '{CMD_WHEEL, 12'd4095, 1'b0, '0},
        '{CMD_WHEEL, 12'd4082, 1'b0, '0},
        '{CMD_WHEEL, 12'd0,    1'b0, '0},
        '{CMD_WHEEL, 12'd0,    1'b0, '0},
        '{CMD_NEXT,  12'd0,    1'b0, '0},
        '{CMD_WHEEL, 12'd81,   1'b0, '0},
        '{CMD_WHEEL, 12'd0,    1'b0, '0},
        '{CMD_NEXT,  12'd0,    1'b0, '0},
        '{CMD_WHEEL, 12'd4095, 1'b0, '0},
        '{CMD_NEXT,  12'd0,    1'b0, '0},
        '{CMD_WHEEL, 12'd4000, 1'b0, '0},
        '{CMD_NEXT,  12'd0,    1'b0, '0},
        '{CMD_WHEEL, 12'd3919, 1'b0, '0},
        '{CMD_NEXT,  12'd0,    1'b0, '0},
        '{CMD_EXIT,  12'd0,    1'b0, '0}
    };

    calendar_clock_with_wheel_edit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .wheel_sample     (wheel_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .editing          (editing),
        .selected_field   (selected_field)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int month_days(input int m);
        int n;
        case (m)
            1:              n = 29;
            3, 5, 8, 10:    n = 30;
            default:        n = 31;
        endcase
        return n;
    endfunction

    function automatic time_rec_t decode_clock();
        time_rec_t r;
        int doy;
        int rem;
        int m;
        doy = clock_secs / SEC_DAY;
        rem = clock_secs % SEC_DAY;
        m = 0;
        while (m < 11 && doy >= month_days(m))
        begin
            doy -= month_days(m);
            m++;
        end
        r.mon   = m[MONTH_W-1:0];
        r.day   = doy[DAY_W-1:0];
        r.hr    = HOUR_W'(rem / SEC_HOUR);
        r.mins  = MIN_W'((rem % SEC_HOUR) / 60);
        r.secs  = SEC_W'(rem % 60);
        r.edit  = edit_on;
        r.field = cur_field;
        return r;
    endfunction

    function automatic int step_secs(input bit up);
        time_rec_t now;
        int m;
        int n;
        now = decode_clock();
        m = int'(now.mon);
        case (cur_field)
            UNIT_MONTH: n = up ? month_days(m) * SEC_DAY
                               : month_days(m == 0 ? 11 : m - 1) * SEC_DAY;
            UNIT_DAY:   n = SEC_DAY;
            UNIT_HOUR:  n = SEC_HOUR;
            UNIT_MIN:   n = 60;
            default:    n = 1;
        endcase
        return n;
    endfunction

    // Applies one command to the shadow clock and returns the time it reports.
    function automatic time_rec_t advance_clock(input logic [CMD_W-1:0] c,
                                                input logic [WHEEL_W-1:0] w);
        int s;
        int l;
        s = int'(w);
        l = int'(prev_wheel);
        case (c)
            CMD_TICK:
                if (!edit_on)
                    clock_secs = (clock_secs + 1) % YEAR_SECS;
            CMD_ENTER:
                if (!edit_on)
                begin
                    edit_on = 1'b1;
                    cur_field = UNIT_MONTH;
                    prev_wheel = w;
                end
            CMD_NEXT:
                if (edit_on)
                    cur_field = (cur_field >= UNIT_SEC) ? UNIT_MONTH : cur_field + 3'd1;
            CMD_WHEEL:
                if (edit_on)
                begin
                    if (s > WHEEL_TOP || l + WHEEL_DELTA < s)
                    begin
                        clock_secs = (clock_secs + step_secs(1'b1)) % YEAR_SECS;
                        prev_wheel = w;
                    end
                    else if (l - WHEEL_DELTA > s)
                    begin
                        clock_secs = (clock_secs + YEAR_SECS - step_secs(1'b0)) % YEAR_SECS;
                        prev_wheel = w;
                    end
                end
            CMD_EXIT:
                edit_on = 1'b0;
            default:
                ;
        endcase
        return decode_clock();
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic drive_item(input logic [CMD_W-1:0] c, input logic [WHEEL_W-1:0] w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        wheel_sample <= w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [WHEEL_W-1:0] w);
        expected_times.push_back(advance_clock(c, w));
        rand_sent++;
        drive_item(c, w);
    endtask

    task automatic edit_session();
        int n;
        int k;
        int kind;
        int last;
        int samp;
        if (!edit_on)
            send_item(CMD_ENTER, WHEEL_W'($urandom));
        n = int'($urandom_range(2, 30));
        for (k = 0; k < n; k++)
        begin
            kind = int'($urandom_range(19));
            last = int'(prev_wheel);
            if (kind < 4)
                send_item(CMD_NEXT, WHEEL_W'($urandom));
            else if (kind == 4)
                send_item(CMD_TICK, WHEEL_W'($urandom));
            else
            begin
                if (kind <= 8)
                begin
                    samp = last + int'($urandom_range(81, 400));
                    if (samp > 4095)
                        samp = int'($urandom_range(4083, 4095));
                end
                else if (kind <= 12)
                begin
                    samp = last - int'($urandom_range(81, 400));
                    if (samp < 0)
                        samp = int'($urandom_range(0, 40));
                end
                else if (kind == 13)
                    samp = last + WHEEL_DELTA;
                else if (kind == 14)
                    samp = last - WHEEL_DELTA;
                else if (kind == 15)
                    samp = last + WHEEL_DELTA + 1;
                else if (kind == 16)
                    samp = last - WHEEL_DELTA - 1;
                else if (kind == 17)
                    samp = int'($urandom_range(WHEEL_TOP, WHEEL_TOP + 1));
                else
                    samp = int'($urandom_range(4095));
                if (samp > 4095)
                    samp = 4095;
                if (samp < 0)
                    samp = 0;
                send_item(CMD_WHEEL, samp[WHEEL_W-1:0]);
            end
        end
        if ($urandom_range(9) != 0)
            send_item(CMD_EXIT, WHEEL_W'($urandom));
    endtask

    // Edits the clock up to Dec 30 (last day) 23:59:59, then ticks across the year end.
    task automatic walk_to_year_end();
        int i;
        int j;
        int v;
        int tgt;
        int span;
        int w;
        int guard;
        bit done;
        logic [FIELD_W-1:0] f;
        time_rec_t now;
        for (i = 0; i < 5; i++)
        begin
            case (i)
                0:       f = UNIT_SEC;
                1:       f = UNIT_MIN;
                2:       f = UNIT_HOUR;
                3:       f = UNIT_MONTH;
                default: f = UNIT_DAY;
            endcase
            if (edit_on)
                send_item(CMD_EXIT, WHEEL_W'($urandom));
            send_item(CMD_ENTER, 12'hfff);
            for (j = 0; j < int'(f); j++)
                send_item(CMD_NEXT, WHEEL_W'($urandom));
            w = 4095;
            done = 1'b0;
            guard = 0;
            while (!done && guard < 40)
            begin
                now = decode_clock();
                case (f)
                    UNIT_SEC:   begin v = int'(now.secs); tgt = 59; span = 60; end
                    UNIT_MIN:   begin v = int'(now.mins); tgt = 59; span = 60; end
                    UNIT_HOUR:  begin v = int'(now.hr);   tgt = 23; span = 24; end
                    UNIT_MONTH: begin v = int'(now.mon);  tgt = 11; span = 0;  end
                    default:    begin v = int'(now.day);  tgt = 30; span = 0;  end
                endcase
                if (v == tgt)
                    done = 1'b1;
                else if (span == 0 || (tgt - v + span) % span <= span / 2)
                    send_item(CMD_WHEEL, 12'hfff);
                else
                begin
                    w -= 100;
                    send_item(CMD_WHEEL, w[WHEEL_W-1:0]);
                end
                guard++;
            end
            send_item(CMD_EXIT, WHEEL_W'($urandom));
        end
        repeat (3) send_item(CMD_TICK, WHEEL_W'($urandom));
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_time = '{month_index, day_of_month, hour_of_day, minute_of_hour,
                         second_of_minute, editing, selected_field};
            if (expected_times.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: unexpected result transfer, mon %0d day %0d %0d:%0d:%0d",
                             $realtime, got_time.mon, got_time.day, got_time.hr,
                             got_time.mins, got_time.secs);
            end
            else
            begin
                want_time = expected_times.pop_front();
                if (got_time.mon != want_time.mon || got_time.day != want_time.day
                    || got_time.hr != want_time.hr || got_time.mins != want_time.mins
                    || got_time.secs != want_time.secs || got_time.edit != want_time.edit
                    || got_time.field != want_time.field)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: mismatch", $realtime,
                                 " exp mon %0d day %0d %0d:%0d:%0d edit %0d fld %0d",
                                 want_time.mon, want_time.day, want_time.hr,
                                 want_time.mins, want_time.secs, want_time.edit,
                                 want_time.field,
                                 "\n         got mon %0d day %0d %0d:%0d:%0d",
                                 got_time.mon, got_time.day, got_time.hr, got_time.mins,
                                 got_time.secs, " edit %0d fld %0d", got_time.edit,
                                 got_time.field);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int pick;
        int walks_done;
        dir_row_t row;
        clock_secs = 9244800;
        edit_on = 1'b0;
        cur_field = UNIT_MONTH;
        prev_wheel = '0;
        walks_done = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_tab[r];
            want_time = advance_clock(row.c, row.w);
            expected_times.push_back(row.typed ? row.want : want_time);
            drive_item(row.c, row.w);
        end

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            case ((rand_sent / 200) % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 84; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 84; end
                default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
            endcase
            pick = int'($urandom_range(99));
            if (walks_done < 3 && rand_sent >= 400 * (walks_done + 1))
            begin
                walk_to_year_end();
                walks_done++;
            end
            else if (pick < 12)
                send_item(CMD_W'($urandom_range(7)), WHEEL_W'($urandom));
            else if (!edit_on && pick < 40)
                repeat ($urandom_range(1, 15)) send_item(CMD_TICK, WHEEL_W'($urandom));
            else
                edit_session();
        end
        in_valid <= 1'b0;

        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (bad_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ccwe_pkg.sv
sv/ccwe_front.sv
sv/ccwe_queue.sv
sv/ccwe_back.sv
sv/calendar_clock_with_wheel_edit.sv
tb/tb_top.sv
